// ===== sv/hpb_pkg.sv =====
// Shared types and helper functions for the hierarchical-Z pyramid builder.
package hpb_pkg;

    localparam int DEPTH_W = 24;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int LVL_W   = 4;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = 24'hFFFFFF;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic               active;
        logic               top;
        logic [DIM_W-1:0]   pw;
        logic [DIM_W-1:0]   ph;
        logic [DIM_W-1:0]   cw;
        logic [DIM_W-1:0]   ch;
    } geo_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] v;
    } tok_t;

    typedef struct packed {
        logic [LVL_W-1:0]   level;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] depth;
        logic               last;
        logic               done;
    } texel_t;

    function automatic logic [DIM_W-1:0] lvl_dim(logic [DIM_W-1:0] d, int m);
        logic [DIM_W-1:0] s;
        s = d >> m;
        return (s == '0) ? DIM_W'(1) : s;
    endfunction

    // level above gets a word (store or emit) from texel (x,y) below
    function automatic logic hpb_needs(logic [COORD_W-1:0] x, geo_t g);
        return g.active && (g.pw == DIM_W'(1) || {2'b00, x} < {g.cw, 1'b0});
    endfunction

    // level above emits a texel from texel (x,y) below
    function automatic logic hpb_emits(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       geo_t g);
        return hpb_needs(x, g) && (g.pw == DIM_W'(1) || x[0]) &&
               (g.ph == DIM_W'(1) || ({2'b00, y} < {g.ch, 1'b0} && y[0]));
    endfunction

    function automatic logic [DEPTH_W-1:0] dmax(logic [DEPTH_W-1:0] a,
                                                logic [DEPTH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== sv/hpb_if.sv =====
// Valid/ready channel interfaces for depth samples and pyramid texels.
interface hpb_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] depth_sample;
    logic        not_finite;
    modport source (output valid, depth_sample, not_finite, input ready);
    modport sink (input valid, depth_sample, not_finite, output ready);
endinterface

interface hpb_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  level;
    logic [11:0] texel_x;
    logic [11:0] texel_y;
    logic [23:0] texel_depth;
    logic        last_of_input;
    logic        frame_done;
    modport source (output valid, level, texel_x, texel_y, texel_depth, last_of_input,
                    frame_done, input ready);
    modport sink (input valid, level, texel_x, texel_y, texel_depth, last_of_input,
                  frame_done, output ready);
endinterface

// ===== sv/hpb_cell.sv =====
// One pyramid level: 2x2 max reduction with pair register and row buffer.
module hpb_cell #(
    parameter int LEVEL   = 1,
    parameter int MAX_DIM = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hpb_pkg::geo_t   geo,
    input  hpb_pkg::geo_t   geo_next,
    input  logic            tok_valid_in,
    input  hpb_pkg::tok_t   tok_in,
    input  logic            slot_free,
    output logic            req,
    output hpb_pkg::texel_t tex,
    output logic            tok_valid_out,
    output hpb_pkg::tok_t   tok_out,
    output logic            idle
);
    import hpb_pkg::*;

    localparam int ROW_N = ((MAX_DIM >> LEVEL) > 2) ? (MAX_DIM >> LEVEL) : 2;
    localparam int AW    = $clog2(ROW_N);
    localparam int DEPTH = 1 << AW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    tok_t               t_reg;
    logic [DEPTH_W-1:0] pair_reg;
    logic [DEPTH_W-1:0] hv_reg;
    logic [DEPTH_W-1:0] rd_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic [DEPTH_W-1:0] row_mem [DEPTH];

    logic               pw_one, ph_one;
    logic [COORD_W-1:0] cx, cy;
    logic [DEPTH_W-1:0] hv1, hv;
    logic               store_pair, y_ok, row_store, go_fin, need_next;

    always_comb
    begin
        pw_one     = (geo.pw == DIM_W'(1));
        ph_one     = (geo.ph == DIM_W'(1));
        cx         = pw_one ? '0 : (t_reg.x >> 1);
        cy         = ph_one ? '0 : (t_reg.y >> 1);
        hv1        = pw_one ? t_reg.v : dmax(pair_reg, t_reg.v);
        store_pair = !pw_one && !t_reg.x[0];
        y_ok       = ph_one || ({2'b00, t_reg.y} < {geo.ch, 1'b0});
        row_store  = !store_pair && !ph_one && y_ok && !t_reg.y[0];
        go_fin     = !store_pair && y_ok && (ph_one || t_reg.y[0]);
        hv         = ph_one ? hv_reg : dmax(rd_reg, hv_reg);
        need_next  = hpb_needs(cx_reg, geo_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_valid_in)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = go_fin ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && tok_valid_in)
        begin
            t_reg <= tok_in;
        end
        if (state_reg == S_READ)
        begin
            if (store_pair)
            begin
                pair_reg <= t_reg.v;
            end
            if (row_store)
            begin
                row_mem[cx[AW-1:0]] <= hv1;
            end
            rd_reg <= row_mem[cx[AW-1:0]];
            hv_reg <= hv1;
            cx_reg <= cx;
            cy_reg <= cy;
        end
    end

    assign req           = (state_reg == S_FIN);
    assign idle          = (state_reg == S_IDLE);
    assign tok_valid_out = req && slot_free && need_next;
    assign tok_out       = '{x: cx_reg, y: cy_reg, v: hv};

    always_comb
    begin
        tex.level = LVL_W'(LEVEL);
        tex.x     = cx_reg;
        tex.y     = cy_reg;
        tex.depth = hv;
        tex.last  = !hpb_emits(cx_reg, cy_reg, geo_next);
        tex.done  = geo.top && ({1'b0, cx_reg} + DIM_W'(1) == geo.cw) &&
                    ({1'b0, cy_reg} + DIM_W'(1) == geo.ch);
    end

    a_tok_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_in |-> state_reg == S_IDLE)
        else $error("word arrived at busy cell");
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg != S_READ)
        else $error("read state held");
    a_tok_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_out |=> state_reg == S_IDLE)
        else $error("cell stayed busy after handoff");
    a_fin_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_FIN) |-> $past(state_reg) == S_READ)
        else $error("finish without read");

endmodule

// ===== sv/hiz_depth_pyramid_builder.sv =====
// Top level: streaming max-depth pyramid builder.
// Depth samples arrive in raster order on the input channel, one word per
// pixel; non-finite samples are forced to 1.0. Each accepted sample yields
// its level-0 texel plus every higher-level texel it completes, lowest
// level first, on the output channel; last_of_input flags the final word of
// a sample and frame_done the top-level texel.
// Level 0 is emitted directly into the output register at accept. Each
// higher level is a cell in a chain; a cell registers the word, reads its
// row buffer, then combines and, if it emits, hands the combined word to
// the next cell. A level that only stores the word goes back to idle
// after the read; the next sample is accepted once the chain is empty and
// the output register can load.
// frame_width/frame_height are written on the cfg port while idle; a write
// restarts the frame at pixel (0,0). Reset gives a 1x1 frame.
// When the receiver stalls, the output word holds and the chain waits.
module hiz_depth_pyramid_builder #(
    parameter int MAX_LEVELS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [12:0] cfg_wdata,
    hpb_in_if.sink      in_ch,
    hpb_out_if.source   out_ch
);
    import hpb_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]   fw_reg, fh_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic               out_valid_reg;
    texel_t             out_reg;

    geo_t               geo [MAX_LEVELS+1];
    logic               tok_v [MAX_LEVELS+1];
    tok_t               tok [MAX_LEVELS+1];
    logic [MAX_LEVELS-1:0] req, idle;
    texel_t             tex [MAX_LEVELS];

    logic               slot_free, accept, emit_any;
    logic [DEPTH_W-1:0] v0;
    logic [DIM_W-1:0]   cfg_clamped;
    texel_t             l0_tex, emit_tex;

    genvar m;
    generate
        for (m = 0; m <= MAX_LEVELS; m++)
        begin : g_geo
            if (m == 0)
            begin : g_base
                assign geo[m].active = 1'b1;
                assign geo[m].pw     = DIM_W'(1);
                assign geo[m].ph     = DIM_W'(1);
            end
            else
            begin : g_up
                assign geo[m].active = (m < MAX_LEVELS) &&
                    (lvl_dim(fw_reg, m - 1) > DIM_W'(1) ||
                     lvl_dim(fh_reg, m - 1) > DIM_W'(1));
                assign geo[m].pw     = lvl_dim(fw_reg, m - 1);
                assign geo[m].ph     = lvl_dim(fh_reg, m - 1);
            end
            assign geo[m].cw = lvl_dim(fw_reg, m);
            assign geo[m].ch = lvl_dim(fh_reg, m);
        end
        for (m = 0; m < MAX_LEVELS; m++)
        begin : g_top
            assign geo[m].top = geo[m].active && !geo[m+1].active;
        end
        assign geo[MAX_LEVELS].top = 1'b0;
    endgenerate

    assign req[0]  = 1'b0;
    assign idle[0] = 1'b1;
    assign tex[0]  = '0;
    assign tok_v[0] = 1'b0;
    assign tok[0]   = '0;

    generate
        for (m = 1; m < MAX_LEVELS; m++)
        begin : g_cell
            hpb_cell #(.LEVEL(m), .MAX_DIM(MAX_DIM)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .geo           (geo[m]),
                .geo_next      (geo[m+1]),
                .tok_valid_in  (tok_v[m]),
                .tok_in        (tok[m]),
                .slot_free     (slot_free),
                .req           (req[m]),
                .tex           (tex[m]),
                .tok_valid_out (tok_v[m+1]),
                .tok_out       (tok[m+1]),
                .idle          (idle[m])
            );
        end
        if (MAX_LEVELS == 1)
        begin : g_no_cell
            assign tok_v[1] = accept && hpb_needs(col_reg, geo[1]);
            assign tok[1]   = '{x: col_reg, y: row_reg, v: v0};
        end
        else
        begin : g_feed
            assign tok_v[1] = accept && hpb_needs(col_reg, geo[1]);
            assign tok[1]   = '{x: col_reg, y: row_reg, v: v0};
        end
    endgenerate

    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = slot_free && (&idle);
    assign accept      = in_ch.valid && in_ch.ready;
    assign v0          = in_ch.not_finite ? DEPTH_ONE : in_ch.depth_sample;
    assign emit_any    = |req;

    always_comb
    begin
        l0_tex.level = '0;
        l0_tex.x     = col_reg;
        l0_tex.y     = row_reg;
        l0_tex.depth = v0;
        l0_tex.last  = !hpb_emits(col_reg, row_reg, geo[1]);
        l0_tex.done  = geo[0].top && ({1'b0, col_reg} + DIM_W'(1) == geo[0].cw) &&
                       ({1'b0, row_reg} + DIM_W'(1) == geo[0].ch);
        emit_tex = '0;
        for (int i = 1; i < MAX_LEVELS; i++)
        begin
            if (req[i])
            begin
                emit_tex = tex[i];
            end
        end
    end

    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            cfg_clamped = DIM_W'(1);
        end
        else if (cfg_wdata > DIM_MAX)
        begin
            cfg_clamped = DIM_MAX;
        end
        else
        begin
            cfg_clamped = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= DIM_W'(1);
            fh_reg        <= DIM_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_FRAME_WIDTH)
                begin
                    fw_reg <= cfg_clamped;
                end
                if (cfg_idx == REG_FRAME_HEIGHT)
                begin
                    fh_reg <= cfg_clamped;
                end
                if (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            else if (accept)
            begin
                if ({1'b0, col_reg} + DIM_W'(1) >= geo[0].cw)
                begin
                    col_reg <= '0;
                    row_reg <= ({1'b0, row_reg} + DIM_W'(1) >= geo[0].ch) ?
                               '0 : row_reg + COORD_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COORD_W'(1);
                end
            end
            if (accept || emit_any)
            begin
                if (slot_free)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= l0_tex;
        end
        else if (emit_any && slot_free)
        begin
            out_reg <= emit_tex;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.level         = out_reg.level;
    assign out_ch.texel_x       = out_reg.x;
    assign out_ch.texel_y       = out_reg.y;
    assign out_ch.texel_depth   = out_reg.depth;
    assign out_ch.last_of_input = out_reg.last;
    assign out_ch.frame_done    = out_reg.done;

    a_one_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(req))
        else $error("several cells emit at once");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !emit_any)
        else $error("sample accepted while chain emits");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("output word lost under stall");
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any && slot_free && emit_tex.last |=> !emit_any)
        else $error("emission after last word");

endmodule
